// ===== rtl/b64e_pkg.sv =====
// shared types, constants and the alphabet function of the base64 encoder
// no dependencies
`default_nettype none

package b64e_pkg;

    localparam int CHAR_W   = 7;
    localparam int JOB_SLOTS = 4;   // characters one byte can produce before escaping

    localparam logic [CHAR_W-1:0] CHAR_PLUS  = 7'h2B;  // '+'
    localparam logic [CHAR_W-1:0] CHAR_SLASH = 7'h2F;  // '/'
    localparam logic [CHAR_W-1:0] CHAR_PCT   = 7'h25;  // '%'
    localparam logic [CHAR_W-1:0] CHAR_TWO   = 7'h32;  // '2'
    localparam logic [CHAR_W-1:0] CHAR_LOWB  = 7'h62;  // 'b'
    localparam logic [CHAR_W-1:0] CHAR_PAD   = 7'h3D;  // '='
    localparam logic [CHAR_W-1:0] CHAR_UPA   = 7'h41;  // 'A'
    localparam logic [CHAR_W-1:0] CHAR_LOWA  = 7'h61;  // 'a'
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;  // '0'

    // position within the 3-byte group
    typedef enum logic [1:0] {
        PH_START = 2'd0,
        PH_ONE   = 2'd1,
        PH_TWO   = 2'd2
    } phase_t;

    // step within an escaped plus
    typedef enum logic [1:0] {
        ESC_PCT  = 2'd0,
        ESC_TWO  = 2'd1,
        ESC_LOWB = 2'd2
    } esc_step_t;

    // characters produced by one input byte, before escaping
    typedef struct packed {
        logic [JOB_SLOTS-1:0][CHAR_W-1:0] chars;
        logic [1:0]                       last_idx;
        logic                             last;
    } job_t;

    // one output word
    typedef struct packed {
        logic [CHAR_W-1:0] out_char;
        logic              last_char;
        logic              run_end;
    } out_word_t;

    function automatic logic [CHAR_W-1:0] b64_char(input logic [5:0] v);
        logic [CHAR_W-1:0] v7;
        v7 = {1'b0, v};
        if (v < 6'd26)
            return CHAR_UPA + v7;
        else if (v < 6'd52)
            return CHAR_LOWA + v7 - 7'd26;
        else if (v < 6'd62)
            return CHAR_ZERO + v7 - 7'd52;
        else if (v == 6'd62)
            return CHAR_PLUS;
        else
            return CHAR_SLASH;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/base64_encoder_plus_escape.sv =====
// top level of the streaming base64 encoder with optional plus escaping
// depends on b64e_pkg, b64e_front, b64e_jobq, b64e_back
`default_nettype none

// usage
// - input side is a queue: drive data_byte and last_byte, raise push; the byte
//   is taken at an edge where push is high and full is low
// - result side is a queue: while empty is low, out_char, last_char and run_end
//   show the oldest word; it is taken at an edge where pop is high
// - run_end marks the last word caused by a byte, last_char the final word of
//   a message (the byte carrying last_byte)
// - plus_escape is written through cfg_valid/cfg_ready (ready always high) and
//   must only change while the block is idle; 1 turns each '+' into "%2b"
// - a byte's first word reaches the result side through two registered queues:
//   front translates it into the job queue at the edge that takes it, and back
//   later emits it into the output queue once that queue has room
// - the back end emits one word per cycle while the output queue has room; a byte
//   causes 1 or 2 words mostly, up to 6 with padding and escaping;
//   a two-entry job queue lets the front take new bytes meanwhile
// - when pop stays low the two-word output queue fills, the back end stops,
//   the job queue fills and full rises; nothing is lost
// - reset clears group phase, leftover bits, both queues and plus_escape
module base64_encoder_plus_escape (
    input  wire logic       clk,
    input  wire logic       rst_n,
    // input queue side
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] data_byte,
    input  wire logic       last_byte,
    // result queue side
    output logic            empty,
    input  wire logic       pop,
    output logic [6:0]      out_char,
    output logic            last_char,
    output logic            run_end,
    // configuration write channel
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic       plus_escape
);
    import b64e_pkg::*;

    logic       esc_reg;
    logic       accept;
    logic       job_valid, job_pop;
    job_t       front_job, head_job;
    out_word_t  head_word;

    // config register, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            esc_reg <= 1'b0;
        else if (cfg_valid && cfg_ready)
            esc_reg <= plus_escape;
    end

    // a byte is taken whenever the job queue has room
    assign accept = push && !full;

    // front: phase, leftover bits, translation to characters
    b64e_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .job       (front_job)
    );

    // decoupling queue, lets front and back stall separately
    b64e_jobq u_jobq (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (accept),
        .wr_job (front_job),
        .full   (full),
        .rd_en  (job_pop),
        .valid  (job_valid),
        .rd_job (head_job)
    );

    // back: one word per cycle into the output queue while it has room
    b64e_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .plus_escape (esc_reg),
        .job_valid   (job_valid),
        .job         (head_job),
        .job_pop     (job_pop),
        .empty       (empty),
        .pop         (pop),
        .head        (head_word)
    );

    assign out_char  = head_word.out_char;
    assign last_char = head_word.last_char;
    assign run_end   = head_word.run_end;

endmodule

`default_nettype wire

// ===== rtl/b64e_front.sv =====
// front end: group phase tracking and sextet-to-character translation per byte
// depends on b64e_pkg
`default_nettype none

module b64e_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           accept,
    input  wire logic [7:0]     data_byte,
    input  wire logic           last_byte,
    output b64e_pkg::job_t      job
);
    import b64e_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [3:0] left_reg, left_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            left_reg  <= 4'd0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
        end
    end

    // next state
    always_comb
    begin
        unique case (phase_reg)
            PH_ONE:
            begin
                phase_next = PH_TWO;
                left_next  = data_byte[3:0];
            end
            PH_TWO:
            begin
                phase_next = PH_START;
                left_next  = 4'd0;
            end
            default:
            begin
                phase_next = PH_ONE;
                left_next  = {2'b00, data_byte[1:0]};
            end
        endcase
        if (last_byte)
        begin
            phase_next = PH_START;
            left_next  = 4'd0;
        end
    end

    // characters for this byte
    always_comb
    begin
        job.chars    = {JOB_SLOTS{CHAR_PAD}};
        job.last     = last_byte;
        unique case (phase_reg)
            PH_ONE:
            begin
                job.chars[0] = b64_char({left_reg[1:0], data_byte[7:4]});
                job.chars[1] = b64_char({data_byte[3:0], 2'b00});
                job.last_idx = last_byte ? 2'd2 : 2'd0;
            end
            PH_TWO:
            begin
                job.chars[0] = b64_char({left_reg, data_byte[7:6]});
                job.chars[1] = b64_char(data_byte[5:0]);
                job.last_idx = 2'd1;
            end
            default:
            begin
                job.chars[0] = b64_char(data_byte[7:2]);
                job.chars[1] = b64_char({data_byte[1:0], 4'b0000});
                job.last_idx = last_byte ? 2'd3 : 2'd0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/b64e_jobq.sv =====
// two-entry queue of per-byte character jobs between front and back
// depends on b64e_pkg
`default_nettype none

module b64e_jobq (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           wr_en,
    input  wire b64e_pkg::job_t wr_job,
    output logic                full,
    input  wire logic           rd_en,
    output logic                valid,
    output b64e_pkg::job_t      rd_job
);
    import b64e_pkg::*;

    job_t       mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;

    assign full   = (count_reg == 2'd2);
    assign valid  = (count_reg != 2'd0);
    assign rd_job = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (wr_en && !rd_en)
            count_next = count_reg + 2'd1;
        else if (rd_en && !wr_en)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (wr_en)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (rd_en)
                rd_ptr_reg <= ~rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_ptr_reg] <= wr_job;
    end

endmodule

`default_nettype wire

// ===== rtl/b64e_back.sv =====
// back end: walks each job one word a cycle while the output queue has room,
// expands escaped plus, and holds results in a two-word output queue; depends on b64e_pkg
`default_nettype none

module b64e_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           plus_escape,
    input  wire logic           job_valid,
    input  wire b64e_pkg::job_t job,
    output logic                job_pop,
    output logic                empty,
    input  wire logic           pop,
    output b64e_pkg::out_word_t head
);
    import b64e_pkg::*;

    logic [1:0]  sym_reg, sym_next;
    esc_step_t   sub_reg, sub_next;
    logic [CHAR_W-1:0] cur_char, emit_char;
    logic        is_plus, char_done, job_done, can_write, fire, out_pop;
    out_word_t   word;

    out_word_t   oq_reg [2];
    logic        owr_ptr_reg, ord_ptr_reg;
    logic [1:0]  ocount_reg;

    assign cur_char  = job.chars[sym_reg];
    assign is_plus   = plus_escape && (cur_char == CHAR_PLUS);
    assign char_done = !is_plus || (sub_reg == ESC_LOWB);
    assign job_done  = char_done && (sym_reg == job.last_idx);

    always_comb
    begin
        emit_char = cur_char;
        if (is_plus)
        begin
            unique case (sub_reg)
                ESC_PCT: emit_char = CHAR_PCT;
                ESC_TWO: emit_char = CHAR_TWO;
                default: emit_char = CHAR_LOWB;
            endcase
        end
    end

    assign out_pop   = pop && !empty;
    assign can_write = (ocount_reg != 2'd2) || out_pop;
    assign fire      = job_valid && can_write;
    assign job_pop   = fire && job_done;

    assign word.out_char  = emit_char;
    assign word.last_char = job_done && job.last;
    assign word.run_end   = job_done;

    always_comb
    begin
        sym_next = sym_reg;
        sub_next = sub_reg;
        if (fire)
        begin
            priority if (job_done)
            begin
                sym_next = 2'd0;
                sub_next = ESC_PCT;
            end
            else if (char_done)
            begin
                sym_next = sym_reg + 2'd1;
                sub_next = ESC_PCT;
            end
            else
            begin
                sub_next = esc_step_t'(sub_reg + 2'd1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sym_reg     <= 2'd0;
            sub_reg     <= ESC_PCT;
            owr_ptr_reg <= 1'b0;
            ord_ptr_reg <= 1'b0;
            ocount_reg  <= 2'd0;
        end
        else
        begin
            sym_reg <= sym_next;
            sub_reg <= sub_next;
            if (fire)
                owr_ptr_reg <= ~owr_ptr_reg;
            if (out_pop)
                ord_ptr_reg <= ~ord_ptr_reg;
            if (fire && !out_pop)
                ocount_reg <= ocount_reg + 2'd1;
            else if (out_pop && !fire)
                ocount_reg <= ocount_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
            oq_reg[owr_ptr_reg] <= word;
    end

    assign empty = (ocount_reg == 2'd0);
    assign head  = oq_reg[ord_ptr_reg];

endmodule

`default_nettype wire

// ===== tb/sv/base64_encoder_plus_escape_test.sv =====
// self-checking test of the streaming base64 encoder with optional plus escaping
// depends on b64e_pkg and base64_encoder_plus_escape; needs nothing else
`default_nettype none

module base64_encoder_plus_escape_test;

    import b64e_pkg::*;

    // run length guard, far above the slowest legal run
    localparam int CYCLE_LIMIT = 200000;

    // standard alphabet, character i sits at bits [8*(63-i) +: 8]
    localparam logic [8*64-1:0] B64_ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    // dut inputs, all known from time zero
    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       push        = 1'b0;
    logic [7:0] data_byte   = 8'h00;
    logic       last_byte   = 1'b0;
    logic       pop         = 1'b0;
    logic       cfg_valid   = 1'b0;
    logic       plus_escape = 1'b0;

    // dut outputs
    logic       full;
    logic       empty;
    logic [6:0] out_char;
    logic       last_char;
    logic       run_end;
    logic       cfg_ready;

    // encoder state as predicted by the test
    phase_t     enc_phase  = PH_START;
    logic [3:0] enc_left   = 4'h0;
    logic       enc_escape = 1'b0;

    // characters of the byte being predicted, then the words still owed by the dut
    logic [6:0] step_chars[$];
    out_word_t  expected_words[$];
    out_word_t  head_word;

    int error_count = 0;
    int cycle_count = 0;

    // sender pacing: bursts of random length with gaps between them
    logic sender_gaps = 1'b1;
    int   burst_left  = 0;

    // receiver pacing: its own run pattern, plus a long hold-off on request
    logic recv_stalls  = 1'b1;
    int   pop_run      = 0;
    logic pop_level    = 1'b1;
    int   holdoff_left = 0;

    base64_encoder_plus_escape dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .data_byte   (data_byte),
        .last_byte   (last_byte),
        .empty       (empty),
        .pop         (pop),
        .out_char    (out_char),
        .last_char   (last_char),
        .run_end     (run_end),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .plus_escape (plus_escape)
    );

    // 10 unit clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // one sextet becomes one character, or three when a plus is escaped
    function automatic void add_sextet(input logic [5:0] v);
        logic [7:0] c;
        c = B64_ALPHABET[8*(63-v) +: 8];
        if (enc_escape && c[6:0] == CHAR_PLUS)
        begin
            step_chars.push_back(CHAR_PCT);
            step_chars.push_back(CHAR_TWO);
            step_chars.push_back(CHAR_LOWB);
        end
        else
            step_chars.push_back(c[6:0]);
    endfunction

    // predict every word one accepted byte causes and queue them up
    function automatic void encode_byte(input logic [7:0] b, input logic last);
        out_word_t w;
        int        n;
        step_chars.delete();
        case (enc_phase)
            PH_ONE:
            begin
                // two leftover bits join the high nibble
                add_sextet({enc_left[1:0], b[7:4]});
                enc_left  = b[3:0];
                enc_phase = PH_TWO;
                if (last)
                begin
                    add_sextet({enc_left, 2'b00});
                    step_chars.push_back(CHAR_PAD);
                end
            end
            PH_TWO:
            begin
                // group complete, two characters
                add_sextet({enc_left, b[7:6]});
                add_sextet(b[5:0]);
                enc_left  = 4'h0;
                enc_phase = PH_START;
            end
            default:
            begin
                // start of group, unused phase behaves the same
                add_sextet(b[7:2]);
                enc_left  = {2'b00, b[1:0]};
                enc_phase = PH_ONE;
                if (last)
                begin
                    add_sextet({enc_left[1:0], 4'h0});
                    step_chars.push_back(CHAR_PAD);
                    step_chars.push_back(CHAR_PAD);
                end
            end
        endcase
        if (last)
        begin
            // message end, next byte opens a new group
            enc_phase = PH_START;
            enc_left  = 4'h0;
        end
        n = step_chars.size();
        for (int i = 0; i < n; i++)
        begin
            w.out_char  = step_chars[i];
            w.run_end   = (i == n - 1);
            w.last_char = last && (i == n - 1);
            expected_words.push_back(w);
        end
    endfunction

    // random byte, biased toward values that make plus characters
    function automatic logic [7:0] pick_byte();
        logic [7:0] r;
        r = $urandom_range(0, 255);
        case ($urandom_range(0, 9))
            0: return {6'h3E, r[1:0]};   // plus at group start
            1: return {r[7:6], 6'h3E};   // plus in the fourth sextet
            2: return {4'hE, r[3:0]};    // plus in the second sextet after xx11
            3: return {r[7:4], 4'hF};    // sets up a plus in the third group byte
            4: return 8'hFF;
            5: return 8'h00;
            default: return r;
        endcase
    endfunction

    // sender gap between bursts; push drops only here or when draining
    task automatic pace_sender();
        if (sender_gaps)
        begin
            if (burst_left > 0)
                burst_left--;
            else
            begin
                push <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                                         : $urandom_range(0, 10);
            end
        end
    endtask

    // offer one byte and predict its words at the edge that takes it
    task automatic send_byte(input logic [7:0] b, input logic last);
        push      <= 1'b1;
        data_byte <= b;
        last_byte <= last;
        do
            @(posedge clk);
        while (full);
        encode_byte(b, last);
        pace_sender();
    endtask

    // stop offering and wait until every owed word has come out
    task automatic wait_drained();
        push <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
    endtask

    // config write, only with the block idle
    task automatic write_plus_escape(input logic v);
        wait_drained();
        cfg_valid   <= 1'b1;
        plus_escape <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        enc_escape = v;
        cfg_valid <= 1'b0;
    endtask

    // receiver: checks each popped word, then picks pop for the next cycle
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (expected_words.size() == 0)
            begin
                $display("%0t: unexpected word: expected none, actual char %h last %b end %b",
                         $time, out_char, last_char, run_end);
                error_count++;
            end
            else
            begin
                head_word = expected_words.pop_front();
                if (out_char !== head_word.out_char)
                begin
                    $display("%0t: out_char mismatch: expected %h, actual %h",
                             $time, head_word.out_char, out_char);
                    error_count++;
                end
                if (last_char !== head_word.last_char)
                begin
                    $display("%0t: last_char mismatch: expected %b, actual %b",
                             $time, head_word.last_char, last_char);
                    error_count++;
                end
                if (run_end !== head_word.run_end)
                begin
                    $display("%0t: run_end mismatch: expected %b, actual %b",
                             $time, head_word.run_end, run_end);
                    error_count++;
                end
            end
        end
        if (holdoff_left > 0)
        begin
            // long hold-off so the block fills and raises full
            holdoff_left = holdoff_left - 1;
            pop <= 1'b0;
        end
        else if (!recv_stalls)
            pop <= 1'b1;
        else
        begin
            // runs of pops and runs of stalls, each of random length
            if (pop_run == 0)
            begin
                pop_level = ($urandom_range(0, 3) != 0);
                pop_run   = pop_level ? $urandom_range(1, 12) : $urandom_range(1, 4);
            end
            pop_run = pop_run - 1;
            pop <= pop_level;
        end
    end

    // padding after one and two bytes, full groups, a bare plus
    task automatic test_plain_padding();
        write_plus_escape(1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hF8, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b1);
    endtask

    // escaped plus in every sextet position, the six-word bytes among them
    task automatic test_plus_escape();
        write_plus_escape(1'b1);
        // plus then padding at group start
        send_byte(8'hFB, 1'b1);
        // plus in the second sextet, then padding
        send_byte(8'h03, 1'b0);
        send_byte(8'hE0, 1'b1);
        // two escaped plus characters from one byte
        send_byte(8'h00, 1'b0);
        send_byte(8'h0F, 1'b0);
        send_byte(8'hBE, 1'b1);
        send_byte(8'hF8, 1'b0);
        send_byte(8'hFF, 1'b1);
    endtask

    // mostly well-formed messages with random content, some with random last flags
    task automatic test_random_traffic();
        int         sent;
        int         len;
        logic       noisy;
        logic [7:0] b;
        logic       l;
        for (int ph = 0; ph < 5; ph++)
        begin
            write_plus_escape(ph[0] == 1'b0);
            // middle phase runs with no idling on either side
            sender_gaps = (ph != 2);
            recv_stalls = (ph != 2);
            sent = 0;
            while (sent < 55)
            begin
                len   = $urandom_range(1, 9);
                noisy = ($urandom_range(0, 7) == 0);
                for (int k = 0; k < len; k++)
                begin
                    b = pick_byte();
                    l = noisy ? 1'($urandom_range(0, 1)) : (k == len - 1);
                    send_byte(b, l);
                    sent++;
                end
            end
        end
        sender_gaps = 1'b1;
        recv_stalls = 1'b1;
    endtask

    // receiver holds off while the sender keeps offering, so full rises
    task automatic test_receiver_holdoff();
        write_plus_escape(1'b1);
        sender_gaps  = 1'b0;
        holdoff_left = 300;
        for (int k = 0; k < 30; k++)
            send_byte(pick_byte(), (k % 7) == 6);
        sender_gaps = 1'b1;
    endtask

    // sender pauses until every word is out, then goes on
    task automatic test_sender_pause();
        write_plus_escape(1'b0);
        send_byte(8'hFB, 1'b0);
        send_byte(8'hEF, 1'b0);
        wait_drained();
        send_byte(8'hBE, 1'b0);
        send_byte(8'h3F, 1'b1);
    endtask

    // main sequence
    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_plain_padding();
        test_plus_escape();
        test_random_traffic();
        test_receiver_holdoff();
        test_sender_pause();
        wait_drained();
        // stray words after the last expected one count as failures
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("base64_encoder_plus_escape_test OK");
        else
            $display("base64_encoder_plus_escape_test NOT OK");
        $finish;
    end

    // timeout guard
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("%0t: timeout after %0d cycles", $time, cycle_count);
        $display("base64_encoder_plus_escape_test NOT OK");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/b64e_pkg.sv
rtl/b64e_front.sv
rtl/b64e_jobq.sv
rtl/b64e_back.sv
rtl/base64_encoder_plus_escape.sv
tb/sv/base64_encoder_plus_escape_test.sv
